/* hdl/sd_card_spi_block_sequencer_defines.svh */
// assertion macros for the sd card spi block sequencer
`ifndef SD_CARD_SPI_BLOCK_SEQUENCER_DEFINES_SVH
`define SD_CARD_SPI_BLOCK_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define SDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SDS_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SDS_ASSERT(label, clk, rst, prop, msg)
`define SDS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* hdl/sdspi_pkg.sv */
// shared types and constants of the sd card spi block sequencer
package sdspi_pkg;
   typedef enum logic [4:0] {
      P_IDLE, P_WAKE, P_CMD, P_POLL, E_POLL, P_GAP, P_TOKEN, E_TOKEN,
      P_RDATA, E_RDATA, P_PRE, P_STARTTOK, P_WDATA, P_CRC, P_DRESP,
      E_DRESP, P_BUSY, E_BUSY, P_FINISH
   } phase_type;

   typedef enum logic [1:0] {JOB_INIT0, JOB_INIT1, JOB_READ, JOB_WRITE} job_type;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_INIT  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_WRITE = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_IDLE  = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_CRC_ERR  = 3'd3;
   localparam logic [2:0] ST_BAD_RESP = 3'd4;

   localparam logic [7:0] CMD_BASE   = 8'h40;
   localparam logic [7:0] CRC_CMD0   = 8'h95;
   localparam logic [31:0] ARG_CMD1  = 32'h00ffc000;
   localparam logic [7:0] DATA_TOKEN = 8'hfe;
   localparam logic [3:0] NIB_MASK   = 4'hf;
   localparam logic [3:0] RESP_OK    = 4'h5;
   localparam logic [3:0] RESP_CRC   = 4'hb;
   localparam logic [7:0] CODE_WRITE = 8'h18;
   localparam logic [7:0] CODE_READ  = 8'h11;
   localparam logic [7:0] IDLE_BYTE  = 8'hff;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] block_address;
      logic [9:0]  transfer_length;
      logic [7:0]  card_byte;
      logic [7:0]  write_byte;
   } slot_type;

   typedef struct packed {
      logic [7:0] send_byte;
      logic       select_low;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       write_taken;
      logic       busy_res;
      logic       done_res;
      logic [2:0] status;
   } result_type;
endpackage

/* hdl/sdspi_front.sv */
// input side: slot register queue of depth two in front of the sequencer
module sdspi_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  sdspi_pkg::slot_type slot_in,
   output logic               slot_valid,
   output sdspi_pkg::slot_type slot_out,
   input  logic               slot_take
);
   sdspi_pkg::slot_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic wr_ptr_in, rd_ptr_in;
   logic [1:0] count_in;
   logic do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign slot_valid = (count_ff != 2'd0);
   assign slot_out = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = slot_take && slot_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end
endmodule

/* hdl/sdspi_engine.sv */
// sequencer: turns one slot into one result per step of the card protocol
module sdspi_engine #(
   parameter int BLOCK_BYTES = 512,
   parameter int WAKE_BYTES = 10,
   parameter int POLL_TRIES = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 slot_valid,
   input  sdspi_pkg::slot_type  slot,
   output logic                 slot_take,
   output logic                 res_valid,
   output sdspi_pkg::result_type res,
   input  logic                 res_ready
);
   // counter covers both the block and the wake run
   localparam int CW = $clog2(((BLOCK_BYTES > WAKE_BYTES) ? BLOCK_BYTES : WAKE_BYTES) + 1);

   sdspi_pkg::phase_type phase_ff, phase_in, ph_mid;
   sdspi_pkg::job_type job_ff, job_in, job_mid;
   logic [CW-1:0] cnt_ff, cnt_in, cnt_mid;
   logic [3:0] poll_ff, poll_in;
   logic [31:0] addr_ff, addr_in;
   logic [9:0] len_ff, len_in;
   logic [3:0] nib_ff, nib_in;
   logic [2:0] fin_ff, fin_in, fin_mid;
   sdspi_pkg::result_type r;
   logic [7:0] card;
   logic [7:0] code;
   logic [31:0] arg;
   logic [7:0] crc;
   logic step;

   assign step = slot_valid && res_ready;
   assign slot_take = step;
   assign res_valid = step;
   assign res = r;
   assign card = slot.card_byte;

   // evaluation of the previous slot's card byte
   always_comb begin
      ph_mid = phase_ff;
      job_mid = job_ff;
      cnt_mid = cnt_ff;
      addr_in = addr_ff;
      len_in = len_ff;
      nib_in = nib_ff;
      fin_mid = fin_ff;
      poll_in = poll_ff;
      r = '0;
      r.send_byte = sdspi_pkg::IDLE_BYTE;
      if (phase_ff == sdspi_pkg::P_IDLE) begin
         if (slot.opcode != sdspi_pkg::OP_NONE) begin
            addr_in = slot.block_address;
            len_in = slot.transfer_length;
            cnt_mid = '0;
            poll_in = '0;
            fin_mid = sdspi_pkg::ST_OK;
            if (slot.opcode == sdspi_pkg::OP_INIT) begin
               job_mid = sdspi_pkg::JOB_INIT0;
               ph_mid = sdspi_pkg::P_WAKE;
            end else begin
               job_mid = (slot.opcode == sdspi_pkg::OP_READ) ? sdspi_pkg::JOB_READ
                                                             : sdspi_pkg::JOB_WRITE;
               ph_mid = sdspi_pkg::P_CMD;
            end
         end
      end else begin
         case (phase_ff)
            sdspi_pkg::E_POLL: begin
               if (!(card == 8'h00 || card == 8'h01 || 32'(poll_ff) >= POLL_TRIES)) begin
                  ph_mid = sdspi_pkg::P_POLL;
               end else if (job_ff == sdspi_pkg::JOB_INIT0) begin
                  if (card == 8'h01) ph_mid = sdspi_pkg::P_GAP;
                  else begin
                     fin_mid = sdspi_pkg::ST_NO_IDLE;
                     ph_mid = sdspi_pkg::P_FINISH;
                  end
               end else if (job_ff == sdspi_pkg::JOB_INIT1) begin
                  if (card == 8'h01) ph_mid = sdspi_pkg::P_GAP;
                  else begin
                     fin_mid = sdspi_pkg::ST_OK;
                     ph_mid = sdspi_pkg::P_FINISH;
                  end
               end else if (card != 8'h00) begin
                  fin_mid = sdspi_pkg::ST_REJECTED;
                  ph_mid = sdspi_pkg::P_FINISH;
               end else if (job_ff == sdspi_pkg::JOB_READ) begin
                  ph_mid = sdspi_pkg::P_TOKEN;
               end else begin
                  ph_mid = sdspi_pkg::P_PRE;
                  cnt_mid = '0;
               end
            end
            sdspi_pkg::E_TOKEN: begin
               if (card == sdspi_pkg::DATA_TOKEN) begin
                  ph_mid = sdspi_pkg::P_RDATA;
                  cnt_mid = '0;
               end else ph_mid = sdspi_pkg::P_TOKEN;
            end
            sdspi_pkg::E_RDATA: begin
               if (32'(cnt_ff) < 32'(len_ff)) begin
                  r.read_valid = 1'b1;
                  r.read_byte = card;
               end
               if (32'(cnt_ff) + 1 >= BLOCK_BYTES) begin
                  ph_mid = sdspi_pkg::P_CRC;
                  cnt_mid = '0;
               end else begin
                  ph_mid = sdspi_pkg::P_RDATA;
                  cnt_mid = cnt_ff + CW'(1);
               end
            end
            sdspi_pkg::E_DRESP: begin
               nib_in = card[3:0] & sdspi_pkg::NIB_MASK;
               ph_mid = sdspi_pkg::P_BUSY;
            end
            sdspi_pkg::E_BUSY: begin
               if (card == 8'h00) ph_mid = sdspi_pkg::P_BUSY;
               else begin
                  ph_mid = sdspi_pkg::P_FINISH;
                  fin_mid = (nib_ff == sdspi_pkg::RESP_OK) ? sdspi_pkg::ST_OK :
                            (nib_ff == sdspi_pkg::RESP_CRC) ? sdspi_pkg::ST_CRC_ERR :
                            sdspi_pkg::ST_BAD_RESP;
               end
            end
            default: begin
            end
         endcase
      end

      // command byte source
      case (job_mid)
         sdspi_pkg::JOB_INIT0: begin
            code = 8'h00; arg = '0; crc = sdspi_pkg::CRC_CMD0;
         end
         sdspi_pkg::JOB_INIT1: begin
            code = 8'h01; arg = sdspi_pkg::ARG_CMD1; crc = sdspi_pkg::IDLE_BYTE;
         end
         sdspi_pkg::JOB_READ: begin
            code = sdspi_pkg::CODE_READ; arg = addr_in; crc = sdspi_pkg::IDLE_BYTE;
         end
         default: begin
            code = sdspi_pkg::CODE_WRITE; arg = addr_in; crc = sdspi_pkg::IDLE_BYTE;
         end
      endcase

      // emission of this slot
      phase_in = ph_mid;
      job_in = job_mid;
      cnt_in = cnt_mid;
      fin_in = fin_mid;
      r.select_low = 1'b1;
      r.busy_res = 1'b1;
      unique case (ph_mid)
         sdspi_pkg::P_WAKE: begin
            r.select_low = 1'b0;
            if (32'(cnt_mid) + 1 >= WAKE_BYTES) begin
               phase_in = sdspi_pkg::P_CMD;
               cnt_in = '0;
            end else cnt_in = cnt_mid + CW'(1);
         end
         sdspi_pkg::P_CMD: begin
            case (cnt_mid[2:0])
               3'd0: r.send_byte = sdspi_pkg::CMD_BASE | code;
               3'd1: r.send_byte = arg[31:24];
               3'd2: r.send_byte = arg[23:16];
               3'd3: r.send_byte = arg[15:8];
               3'd4: r.send_byte = arg[7:0];
               default: r.send_byte = crc;
            endcase
            cnt_in = cnt_mid + CW'(1);
            if (cnt_mid >= CW'(5)) begin
               phase_in = sdspi_pkg::P_POLL;
               poll_in = '0;
            end
         end
         sdspi_pkg::P_POLL: begin
            if (poll_in != 4'hf) poll_in = poll_in + 4'd1;
            phase_in = sdspi_pkg::E_POLL;
         end
         sdspi_pkg::P_GAP: begin
            r.select_low = 1'b0;
            job_in = sdspi_pkg::JOB_INIT1;
            phase_in = sdspi_pkg::P_CMD;
            cnt_in = '0;
         end
         sdspi_pkg::P_TOKEN: phase_in = sdspi_pkg::E_TOKEN;
         sdspi_pkg::P_RDATA: phase_in = sdspi_pkg::E_RDATA;
         sdspi_pkg::P_PRE: begin
            cnt_in = cnt_mid + CW'(1);
            if (cnt_mid >= CW'(2)) phase_in = sdspi_pkg::P_STARTTOK;
         end
         sdspi_pkg::P_STARTTOK: begin
            r.send_byte = sdspi_pkg::DATA_TOKEN;
            phase_in = sdspi_pkg::P_WDATA;
            cnt_in = '0;
         end
         sdspi_pkg::P_WDATA: begin
            if (32'(cnt_mid) < 32'(len_ff)) begin
               r.send_byte = slot.write_byte;
               r.write_taken = 1'b1;
            end else r.send_byte = 8'h00;
            if (32'(cnt_mid) + 1 >= BLOCK_BYTES) begin
               phase_in = sdspi_pkg::P_CRC;
               cnt_in = '0;
            end else cnt_in = cnt_mid + CW'(1);
         end
         sdspi_pkg::P_CRC: begin
            cnt_in = cnt_mid + CW'(1);
            if (cnt_mid >= CW'(1)) begin
               if (job_mid == sdspi_pkg::JOB_READ) begin
                  fin_in = sdspi_pkg::ST_OK;
                  phase_in = sdspi_pkg::P_FINISH;
               end else phase_in = sdspi_pkg::P_DRESP;
            end
         end
         sdspi_pkg::P_DRESP: phase_in = sdspi_pkg::E_DRESP;
         sdspi_pkg::P_BUSY: phase_in = sdspi_pkg::E_BUSY;
         sdspi_pkg::P_FINISH: begin
            r.select_low = 1'b0;
            r.done_res = 1'b1;
            r.status = fin_mid;
            phase_in = sdspi_pkg::P_IDLE;
         end
         default: begin
            r.select_low = 1'b0;
            r.busy_res = 1'b0;
            phase_in = sdspi_pkg::P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdspi_pkg::P_IDLE;
         job_ff <= sdspi_pkg::JOB_INIT0;
         cnt_ff <= '0;
         poll_ff <= '0;
         addr_ff <= '0;
         len_ff <= '0;
         nib_ff <= '0;
         fin_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         job_ff <= job_in;
         cnt_ff <= cnt_in;
         poll_ff <= poll_in;
         addr_ff <= addr_in;
         len_ff <= len_in;
         nib_ff <= nib_in;
         fin_ff <= fin_in;
      end
   end

`include "sd_card_spi_block_sequencer_defines.svh"
   `SDS_ASSERT(a_done_busy, clock, reset, !(res_valid && res.done_res) || res.busy_res, "done without busy")
   `SDS_ASSERT(a_idle_quiet, clock, reset, !(res_valid && !res.busy_res) || (res.status == sdspi_pkg::ST_OK && !res.select_low), "idle slot not quiet")
   `SDS_ASSERT(a_finish_idle, clock, reset, (step && phase_ff == sdspi_pkg::P_FINISH) |=> phase_ff == sdspi_pkg::P_IDLE, "finish not followed by idle")
endmodule

/* hdl/sdspi_back.sv */
// output side: two-entry result queue
module sdspi_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  sdspi_pkg::result_type res_in,
   output logic                 res_ready,
   output logic                 empty,
   input  logic                 pop,
   output sdspi_pkg::result_type res_out
);
   sdspi_pkg::result_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic do_push, do_pop;

   assign res_ready = (count_ff != 2'd2);
   assign empty = (count_ff == 2'd0);
   assign res_out = mem_ff[rd_ptr_ff];
   assign do_push = res_valid && res_ready;
   assign do_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ do_push;
         rd_ptr_ff <= rd_ptr_ff ^ do_pop;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

`include "sd_card_spi_block_sequencer_defines.svh"
   `SDS_ASSERT(a_no_overflow, clock, reset, count_ff != 2'd3, "result queue overflow")
   `SDS_ASSERT(a_count_step, clock, reset, (do_push && !do_pop) |=> count_ff == $past(count_ff) + 2'd1, "count did not rise")
   `SDS_ASSERT_RST(a_reset_empty, clock, reset |=> empty, "not empty after reset")
endmodule

/* hdl/sd_card_spi_block_sequencer.sv */
// top level of the sd card spi block sequencer
// One item is one spi byte slot and gives one result; a slot is taken every
// clock cycle when a slot is queued and the result queue has room. The input
// queue holds two slots, the sequencer steps its protocol state once per slot
// and a full two-entry result queue stalls it and then input. Start opcodes are
// ignored while a sequence runs; the token, busy and cmd1 waits never time out.
module sd_card_spi_block_sequencer #(
   parameter int BLOCK_BYTES = 512,
   parameter int WAKE_BYTES = 10,
   parameter int POLL_TRIES = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_block_address,
   input  logic [9:0]  req_transfer_length,
   input  logic [7:0]  req_card_byte,
   input  logic [7:0]  req_write_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_send_byte,
   output logic        rsp_select_low,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_write_taken,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_status
);
   sdspi_pkg::slot_type slot_in, slot;
   sdspi_pkg::result_type res, res_q;
   logic slot_valid, slot_take, res_valid, res_ready;

   assign slot_in = '{opcode: req_opcode, block_address: req_block_address,
                      transfer_length: req_transfer_length,
                      card_byte: req_card_byte, write_byte: req_write_byte};

   sdspi_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .slot_in(slot_in),
      .slot_valid(slot_valid), .slot_out(slot), .slot_take(slot_take)
   );

   sdspi_engine #(
      .BLOCK_BYTES(BLOCK_BYTES), .WAKE_BYTES(WAKE_BYTES), .POLL_TRIES(POLL_TRIES)
   ) u_engine (
      .clock(clock), .reset(reset), .slot_valid(slot_valid), .slot(slot),
      .slot_take(slot_take), .res_valid(res_valid), .res(res), .res_ready(res_ready)
   );

   sdspi_back u_back (
      .clock(clock), .reset(reset), .res_valid(res_valid), .res_in(res),
      .res_ready(res_ready), .empty(empty), .pop(pop), .res_out(res_q)
   );

   assign rsp_send_byte = res_q.send_byte;
   assign rsp_select_low = res_q.select_low;
   assign rsp_read_valid = res_q.read_valid;
   assign rsp_read_byte = res_q.read_byte;
   assign rsp_write_taken = res_q.write_taken;
   assign rsp_busy_res = res_q.busy_res;
   assign rsp_done_res = res_q.done_res;
   assign rsp_status = res_q.status;
endmodule

/* sim/sd_card_spi_block_sequencer_check.sv */
// checker for the sd card spi block sequencer: predicts each slot result and compares
module sd_card_spi_block_sequencer_check
   import sdspi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_block_address,
   input  logic [9:0]  req_transfer_length,
   input  logic [7:0]  req_card_byte,
   input  logic [7:0]  req_write_byte,
   input  logic        empty,
   input  logic        pop,
   input  logic [7:0]  rsp_send_byte,
   input  logic        rsp_select_low,
   input  logic        rsp_read_valid,
   input  logic [7:0]  rsp_read_byte,
   input  logic        rsp_write_taken,
   input  logic        rsp_busy_res,
   input  logic        rsp_done_res,
   input  logic [2:0]  rsp_status,
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLOCK = 512;
   localparam int WAKE = 10;
   localparam int TRIES = 9;

   phase_type   ph;
   job_type     jb;
   int          cnt;
   int          polls;
   logic [31:0] h_addr;
   logic [9:0]  h_len;
   logic [3:0]  nib;
   logic [2:0]  fin;
   result_type  slot_q[$];

   function automatic logic [7:0] cmd_byte(int k);
      logic [7:0]  code;
      logic [31:0] arg;
      logic [7:0]  crc;
      case (jb)
         JOB_INIT0: begin code = 8'h00; arg = '0;       crc = CRC_CMD0;  end
         JOB_INIT1: begin code = 8'h01; arg = ARG_CMD1; crc = IDLE_BYTE; end
         JOB_READ:  begin code = CODE_READ;  arg = h_addr; crc = IDLE_BYTE; end
         default:   begin code = CODE_WRITE; arg = h_addr; crc = IDLE_BYTE; end
      endcase
      if (k == 0) return CMD_BASE | code;
      if (k <= 4) return arg[8*(4-k) +: 8];
      return crc;
   endfunction

   function automatic void finish_with(logic [2:0] st);
      fin = st;
      ph = P_FINISH;
   endfunction

   function automatic result_type slot_result(slot_type s);
      result_type r;
      r = '0;
      if (ph == P_IDLE) begin
         if (s.opcode == OP_NONE) begin
            r.send_byte = IDLE_BYTE;
            return r;
         end
         h_addr = s.block_address;
         h_len = s.transfer_length;
         cnt = 0;
         polls = 0;
         fin = ST_OK;
         if (s.opcode == OP_INIT) begin
            jb = JOB_INIT0;
            ph = P_WAKE;
         end else begin
            jb = (s.opcode == OP_READ) ? JOB_READ : JOB_WRITE;
            ph = P_CMD;
         end
      end else begin
         // judge the byte the card returned in the previous slot
         case (ph)
            E_POLL: begin
               if (!(s.card_byte == 8'h00 || s.card_byte == 8'h01 || polls >= TRIES))
                  ph = P_POLL;
               else if (jb == JOB_INIT0) begin
                  if (s.card_byte == 8'h01) ph = P_GAP; else finish_with(ST_NO_IDLE);
               end else if (jb == JOB_INIT1) begin
                  if (s.card_byte == 8'h01) ph = P_GAP; else finish_with(ST_OK);
               end else if (s.card_byte != 8'h00)
                  finish_with(ST_REJECTED);
               else if (jb == JOB_READ)
                  ph = P_TOKEN;
               else begin
                  ph = P_PRE;
                  cnt = 0;
               end
            end
            E_TOKEN: begin
               if (s.card_byte == DATA_TOKEN) begin
                  ph = P_RDATA;
                  cnt = 0;
               end else ph = P_TOKEN;
            end
            E_RDATA: begin
               if (cnt < h_len) begin
                  r.read_valid = 1'b1;
                  r.read_byte = s.card_byte;
               end
               cnt++;
               if (cnt >= BLOCK) begin
                  ph = P_CRC;
                  cnt = 0;
               end else ph = P_RDATA;
            end
            E_DRESP: begin
               nib = s.card_byte[3:0];
               ph = P_BUSY;
            end
            E_BUSY: begin
               if (s.card_byte == 8'h00) ph = P_BUSY;
               else if (nib == RESP_OK) finish_with(ST_OK);
               else if (nib == RESP_CRC) finish_with(ST_CRC_ERR);
               else finish_with(ST_BAD_RESP);
            end
            default: ;
         endcase
      end
      r.send_byte = IDLE_BYTE;
      r.select_low = 1'b1;
      r.busy_res = 1'b1;
      case (ph)
         P_WAKE: begin
            r.select_low = 1'b0;
            cnt++;
            if (cnt >= WAKE) begin
               ph = P_CMD;
               cnt = 0;
            end
         end
         P_CMD: begin
            r.send_byte = cmd_byte(cnt);
            cnt++;
            if (cnt >= 6) begin
               ph = P_POLL;
               polls = 0;
            end
         end
         P_POLL: begin
            if (polls < 15) polls++;
            ph = E_POLL;
         end
         P_GAP: begin
            r.select_low = 1'b0;
            jb = JOB_INIT1;
            ph = P_CMD;
            cnt = 0;
         end
         P_TOKEN: ph = E_TOKEN;
         P_RDATA: ph = E_RDATA;
         P_PRE: begin
            cnt++;
            if (cnt >= 3) ph = P_STARTTOK;
         end
         P_STARTTOK: begin
            r.send_byte = DATA_TOKEN;
            ph = P_WDATA;
            cnt = 0;
         end
         P_WDATA: begin
            if (cnt < h_len) begin
               r.send_byte = s.write_byte;
               r.write_taken = 1'b1;
            end else r.send_byte = 8'h00;
            cnt++;
            if (cnt >= BLOCK) begin
               ph = P_CRC;
               cnt = 0;
            end
         end
         P_CRC: begin
            cnt++;
            if (cnt >= 2) begin
               if (jb == JOB_READ) finish_with(ST_OK);
               else ph = P_DRESP;
            end
         end
         P_DRESP: ph = E_DRESP;
         P_BUSY: ph = E_BUSY;
         P_FINISH: begin
            r.select_low = 1'b0;
            r.done_res = 1'b1;
            r.status = fin;
            ph = P_IDLE;
         end
         default: begin
            r.select_low = 1'b0;
            r.busy_res = 1'b0;
            ph = P_IDLE;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      slot_type   s;
      if (reset) begin
         ph = P_IDLE;
         jb = JOB_INIT0;
         cnt = 0;
         polls = 0;
         h_addr = '0;
         h_len = '0;
         nib = '0;
         fin = ST_OK;
         slot_q.delete();
         errors = 0;
      end else begin
         if (pop && !empty) begin
            got = '{rsp_send_byte, rsp_select_low, rsp_read_valid, rsp_read_byte,
                    rsp_write_taken, rsp_busy_res, rsp_done_res, rsp_status};
            if (slot_q.size() == 0) begin
               $display("%0t: unexpected result transfer, actual %p", $time, got);
               errors++;
            end else begin
               want = slot_q.pop_front();
               if (got.send_byte != want.send_byte || got.select_low != want.select_low ||
                   got.read_valid != want.read_valid || got.read_byte != want.read_byte ||
                   got.write_taken != want.write_taken || got.busy_res != want.busy_res ||
                   got.done_res != want.done_res || got.status != want.status) begin
                  $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
                  errors++;
               end
            end
         end
         if (push && !full) begin
            s = '{req_opcode, req_block_address, req_transfer_length, req_card_byte,
                  req_write_byte};
            slot_q.push_back(slot_result(s));
         end
      end
      pending = slot_q.size();
   end
endmodule

/* sim/sd_card_spi_block_sequencer_test.sv */
// top of the sd card spi block sequencer testbench: clock, reset, stimulus and verdict
module sd_card_spi_block_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sdspi_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_opcode = OP_NONE;
   logic [31:0] req_block_address = '0;
   logic [9:0]  req_transfer_length = '0;
   logic [7:0]  req_card_byte = '0;
   logic [7:0]  req_write_byte = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_send_byte;
   logic        rsp_select_low;
   logic        rsp_read_valid;
   logic [7:0]  rsp_read_byte;
   logic        rsp_write_taken;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [2:0]  rsp_status;
   int          errors;
   int          pending;
   logic        full_s = 1'b1;
   int          cyc = 0;

   always #1 clock = ~clock;

   sd_card_spi_block_sequencer u_top (.*);

   sd_card_spi_block_sequencer_check u_check (.*);

   always @(negedge clock) full_s <= full;

   // receiver stall pattern rotates through always-ready, random and one-in-four pops
   always @(posedge clock) begin
      cyc <= cyc + 1;
      case ((cyc / 400) % 3)
         0: pop <= 1'b1;
         1: pop <= ($urandom_range(0, 1) == 1);
         default: pop <= ((cyc % 4) == 0);
      endcase
   end

   task automatic send_slot(logic [1:0] op, logic [31:0] addr, logic [9:0] len,
                            logic [7:0] card, logic [7:0] wb);
      push <= 1'b1;
      req_opcode <= op;
      req_block_address <= addr;
      req_transfer_length <= len;
      req_card_byte <= card;
      req_write_byte <= wb;
      forever begin
         @(posedge clock);
         if (!full_s) break;
      end
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] card_pick();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'h01;
         2: return DATA_TOKEN;
         3: return {4'($urandom_range(0, 15)), RESP_OK};
         4: return {4'($urandom_range(0, 15)), RESP_CRC};
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic logic [9:0] len_pick();
      case ($urandom_range(0, 5))
         0: return 10'd0;
         1: return 10'd512;
         2: return 10'($urandom_range(513, 1023));
         default: return 10'($urandom_range(0, 40));
      endcase
   endfunction

   initial begin
      int burst;
      logic [1:0] op;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: idle slots, init with idle replies, cmd0 idle reply and cmd1 start, start while busy
      send_slot(OP_NONE, 32'hffffffff, 10'h3ff, 8'hff, 8'hff);
      send_slot(OP_NONE, 32'h0, 10'h0, 8'h00, 8'h00);
      send_slot(OP_INIT, 32'hffffffff, 10'h3ff, 8'h00, 8'hff);
      repeat (10) send_slot(OP_NONE, 32'h0, 10'h0, 8'hff, 8'h00);
      send_slot(OP_READ, 32'h0, 10'd512, 8'hff, 8'h00);
      repeat (5) send_slot(OP_NONE, 32'h0, 10'h0, 8'hff, 8'h00);
      send_slot(OP_NONE, 32'h0, 10'h0, 8'hff, 8'h00);
      send_slot(OP_NONE, 32'h0, 10'h0, 8'h01, 8'h00);
      send_slot(OP_WRITE, 32'h0, 10'h0, 8'h7e, 8'h00);
      send_slot(OP_NONE, 32'h0, 10'h0, 8'h80, 8'h00);
      // random: bursts of slots with random gaps
      for (int i = 0; i < 1900;) begin
         burst = $urandom_range(1, 40);
         for (int j = 0; j < burst && i < 1900; j++, i++) begin
            op = ($urandom_range(0, 25) == 0) ? 2'($urandom_range(1, 3)) : OP_NONE;
            send_slot(op, $urandom(), len_pick(), card_pick(), 8'($urandom()));
         end
         if (i > 950 && i <= 950 + burst) begin
            push <= 1'b0;
            do @(negedge clock); while (pending != 0);
            @(posedge clock);
         end else if ($urandom_range(0, 2) != 0)
            idle_gap($urandom_range(1, 8));
      end
      push <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
